@@ src/rrs_pkg.sv @@
// rrs_pkg: shared widths, constants and payload types for the running rtt statistics block
// no dependencies; imported by running_rtt_statistics, rrs_checker and the testbench

package rrs_pkg;

  localparam int TYPE_W     = 8;
  localparam int RTT_W      = 32;
  localparam int CNT_W      = 32;
  localparam int MEAN_W     = 48;
  localparam int SQ_W       = 64;
  localparam int TMO_W      = 8;
  localparam int LIMIT_W    = 28;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [TYPE_W-1:0]     ICMP_ECHO_REPLY = 8'd0;
  localparam logic [19:0]           US_PER_SECOND   = 20'd1000000;
  localparam logic [TMO_W-1:0]      TIMEOUT_RESET   = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] ADDR_TIMEOUT    = 2'd0;
  localparam logic [CNT_W-1:0]      CNT_MAX         = {CNT_W{1'b1}};
  localparam logic [MEAN_W-1:0]     MEAN_MAX        = {MEAN_W{1'b1}};
  localparam logic [SQ_W-1:0]       SQ_MAX          = {SQ_W{1'b1}};

  // one reply event
  typedef struct packed {
    logic [TYPE_W-1:0] icmp_type;
    logic [RTT_W-1:0]  rtt_us;
  } rrs_in_t;

  // statistics after one event
  typedef struct packed {
    logic              counted;
    logic [CNT_W-1:0]  sample_count;
    logic [RTT_W-1:0]  min_rtt;
    logic [RTT_W-1:0]  max_rtt;
    logic [MEAN_W-1:0] mean_rtt;
    logic [SQ_W-1:0]   sq_dev_sum;
  } rrs_out_t;

endpackage

@@ src/rrs_div.sv @@
// rrs_div: bit-serial restoring divider, one quotient bit per cycle
// depends on nothing; used by running_rtt_statistics for the mean step

module rrs_div #(
  parameter int DVD_W = 48,
  parameter int DVS_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  // shift in the next dividend bit and try the subtraction
  assign rem_sh = {rem_r, quo_r[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      rem_nxt = fits ? DVS_W'(rem_sh - {1'b0, dvs_r}) : DVS_W'(rem_sh);
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ src/rrs_mul.sv @@
// rrs_mul: bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on nothing; used by running_rtt_statistics for the squared deviation

module rrs_mul #(
  parameter int W = 48
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   mcand,
  input  logic [W-1:0]   mplier,
  output logic           done,
  output logic [2*W-1:0] product
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  mcand_r;
  logic [W-1:0]  hi_r, hi_nxt;
  logic [W-1:0]  lo_r, lo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    psum;

  // add the multiplicand when the low multiplier bit is set
  assign psum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : {(W+1){1'b0}});

  always_comb begin
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      hi_nxt   = '0;
      lo_nxt   = mplier;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt  = psum[W:1];
      lo_nxt  = {psum[0], lo_r[W-1:1]};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    if (start) begin
      mcand_r <= mcand;
    end
  end

  assign done    = done_r;
  assign product = {hi_r, lo_r};

endmodule

@@ src/running_rtt_statistics.sv @@
// running_rtt_statistics: top level, event check, welford update sequencer, apb register
// depends on rrs_pkg, rrs_div and rrs_mul
//
//   channel   ports                          direction  transfer when
//   input     in_valid in_ready in_data      in         in_valid & in_ready
//   result    out_valid out_ready out_data   out        out_valid & out_ready
//   config    psel penable pwrite paddr ...  in         psel & penable & pwrite
//
// an event that is not counted goes from S_LOAD straight to S_DONE and then to the result
// a counted event passes through the serial divider and then the serial multiplier,
// one bit per cycle each
// one event is worked on at a time; in_ready is high only while the sequencer is idle
// a finished result waits in the output register while the next event is taken in
// synchronous active-low reset clears statistics to zero and the timeout to 1 s

module running_rtt_statistics
  import rrs_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rrs_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rrs_out_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int W  = RTT_W + FRACTION_BITS;
  localparam int SW = ((W > MEAN_W) ? W : MEAN_W) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MEAN = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_SUM  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [TMO_W-1:0]   timeout_r;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic               cfg_wr;

  logic [RTT_W-1:0]   rtt_r;
  logic               take_r;
  logic [W-1:0]       x_r;
  logic [W-1:0]       mag_r;
  logic               ge_r;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [RTT_W-1:0]   min_r;
  logic [RTT_W-1:0]   max_r;
  logic [MEAN_W-1:0]  mean_r;
  logic [SQ_W-1:0]    sq_r;

  rrs_out_t           out_r;
  logic               out_valid_r;

  logic [W-1:0]       x_load;
  logic [SW-1:0]      x_ext, mean_ext, step_ext, new_ext, sum_up;
  logic [MEAN_W-1:0]  new_mean;
  logic [W-1:0]       d2;
  logic               div_start, div_done, mul_start, mul_done;
  logic [W-1:0]       quotient;
  logic [2*W-1:0]     product;
  logic [SQ_W-1:0]    sq_inc;
  logic [SQ_W:0]      sq_sum;
  logic               in_xfer, out_free;

  // apb register: timeout and its limit in microseconds
  assign cfg_wr    = psel && penable && pwrite && (paddr == ADDR_TIMEOUT);
  assign limit_nxt = LIMIT_W'(pwdata[TMO_W-1:0]) * LIMIT_W'(US_PER_SECOND);
  assign prdata    = (paddr == ADDR_TIMEOUT) ? CFG_DATA_W'(timeout_r) : '0;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      limit_r   <= LIMIT_W'(US_PER_SECOND) * LIMIT_W'(TIMEOUT_RESET);
    end else if (cfg_wr) begin
      timeout_r <= pwdata[TMO_W-1:0];
      limit_r   <= limit_nxt;
    end
  end

  // handshake
  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sample in fixed point and its distance to the mean
  assign x_load   = W'(rtt_r) << FRACTION_BITS;
  assign x_ext    = SW'(x_r);
  assign mean_ext = SW'(mean_r);
  assign step_ext = SW'(quotient);
  assign sum_up   = mean_ext + step_ext;
  assign count_nxt = (count_r == CNT_MAX) ? count_r : count_r + CNT_W'(1);

  // new mean, saturated upward, and the second deviation
  always_comb begin
    if (ge_r) begin
      new_mean = (sum_up > SW'(MEAN_MAX)) ? MEAN_MAX : MEAN_W'(sum_up);
    end else begin
      new_mean = MEAN_W'(mean_ext - step_ext);
    end
    new_ext = SW'(new_mean);
    d2      = ge_r ? W'(x_ext - new_ext) : W'(new_ext - x_ext);
  end

  assign div_start = (state_r == S_LOAD) && take_r;
  assign mul_start = (state_r == S_MEAN);

  rrs_div #(
    .DVD_W (W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (W'(x_load >= W'(mean_r) ? x_load - W'(mean_r) : W'(mean_r) - x_load)),
    .divisor  (count_nxt),
    .done     (div_done),
    .quotient (quotient)
  );

  rrs_mul #(
    .W (W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mag_r),
    .mplier  (d2),
    .done    (mul_done),
    .product (product)
  );

  // drop 2*FRACTION_BITS fraction bits, exactly 64 bits remain
  assign sq_inc = product[2*W-1 -: SQ_W];
  assign sq_sum = {1'b0, sq_r} + {1'b0, sq_inc};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_LOAD;
      S_LOAD: state_nxt = take_r ? S_DIV : S_DONE;
      S_DIV:  if (div_done) state_nxt = S_MEAN;
      S_MEAN: state_nxt = S_MUL;
      S_MUL:  if (mul_done) state_nxt = S_SUM;
      S_SUM:  state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and statistics state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      min_r       <= '0;
      max_r       <= '0;
      mean_r      <= '0;
      sq_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == S_LOAD) && take_r) begin
        count_r <= count_nxt;
        if ((count_r == '0) || (rtt_r < min_r)) min_r <= rtt_r;
        if ((count_r == '0) || (rtt_r > max_r)) max_r <= rtt_r;
      end
      if (state_r == S_MEAN) begin
        mean_r <= new_mean;
      end
      if (state_r == S_SUM) begin
        sq_r <= sq_sum[SQ_W] ? SQ_MAX : sq_sum[SQ_W-1:0];
      end
    end
  end

  // event capture, working values and the output register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rtt_r  <= in_data.rtt_us;
      take_r <= (in_data.icmp_type == ICMP_ECHO_REPLY) &&
                (in_data.rtt_us <= RTT_W'(limit_r));
    end
    if (state_r == S_LOAD) begin
      x_r   <= x_load;
      ge_r  <= x_load >= W'(mean_r);
      mag_r <= (x_load >= W'(mean_r)) ? x_load - W'(mean_r) : W'(mean_r) - x_load;
    end
    if ((state_r == S_DONE) && out_free) begin
      out_r.counted      <= take_r;
      out_r.sample_count <= count_r;
      out_r.min_rtt      <= min_r;
      out_r.max_rtt      <= max_r;
      out_r.mean_rtt     <= mean_r;
      out_r.sq_dev_sum   <= sq_r;
    end
  end

endmodule

@@ src/rrs_checker.sv @@
// rrs_checker: port-level checks on running_rtt_statistics, bound to the top level
// depends on rrs_pkg and running_rtt_statistics

module rrs_checker
  import rrs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input rrs_out_t              out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one event at a time: no transfer right after a transfer
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an event is in work");

  // a counted event always leaves a nonzero count
  a_counted_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.counted |-> out_data.sample_count != '0)
    else $error("counted result with zero count");

  // empty statistics read zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.sample_count == '0) |->
      (out_data.min_rtt == '0) && (out_data.max_rtt == '0) &&
      (out_data.mean_rtt == '0) && (out_data.sq_dev_sum == '0))
    else $error("empty statistics not zero");

  // minimum never above maximum
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.min_rtt <= out_data.max_rtt)
    else $error("minimum above maximum");

endmodule

bind running_rtt_statistics rrs_checker u_rrs_checker (.*);

@@ dv/testbench.sv @@
// testbench: self-checking bench for running_rtt_statistics with directed and random traffic
// depends on rrs_pkg and the running_rtt_statistics rtl; predicts every result in step with the dut
`timescale 1ns / 100ps

module testbench;
  import rrs_pkg::*;

  localparam int FRAC           = 16;
  localparam int RESET_CYCLES   = 8;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_EVENTS  = 100;
  localparam int WIDE_SAMPLES   = 228;

  localparam logic [TMO_W-1:0]      TMO_MIN     = 8'd0;
  localparam logic [TMO_W-1:0]      TMO_MAX     = 8'd255;
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED = 2'd1;
  localparam logic [TYPE_W-1:0]     ICMP_UNREACH = 8'd3;
  localparam logic [TYPE_W-1:0]     ICMP_ECHO_REQ = 8'd8;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  rrs_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  rrs_out_t              out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // predictor copy of the timeout register and the statistics
  logic [TMO_W-1:0]  tmo_s;
  logic [CNT_W-1:0]  st_count;
  logic [RTT_W-1:0]  st_min;
  logic [RTT_W-1:0]  st_max;
  logic [MEAN_W-1:0] st_mean;
  logic [SQ_W-1:0]   st_sq;

  rrs_out_t pending_stats[$];
  rrs_out_t want;

  int send_idle_pct;
  int recv_stall_pct;
  int err_count;
  int events_sent;
  int results_seen;
  int counted_seen;
  int quiet_cycles;

  running_rtt_statistics #(
    .FRACTION_BITS(FRAC)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // fold one event into the predicted statistics, return the expected result
  function automatic rrs_out_t fold_event(rrs_in_t ev);
    logic [63:0]  limit;
    logic [63:0]  x;
    logic [63:0]  mean64;
    logic [63:0]  mag;
    logic [63:0]  stp;
    logic [63:0]  nm;
    logic [63:0]  d1;
    logic [63:0]  d2;
    logic [63:0]  inc;
    logic [127:0] prod;
    rrs_out_t     r;
    limit = 64'(tmo_s) * 64'd1000000;
    r.counted = (ev.icmp_type == ICMP_ECHO_REPLY) && (64'(ev.rtt_us) <= limit);
    if (r.counted) begin
      x = 64'(ev.rtt_us) << FRAC;
      if (st_count == '0) begin
        st_min = ev.rtt_us;
        st_max = ev.rtt_us;
      end else begin
        if (ev.rtt_us < st_min) st_min = ev.rtt_us;
        if (ev.rtt_us > st_max) st_max = ev.rtt_us;
      end
      if (st_count != CNT_MAX) st_count = st_count + 1'b1;
      mean64 = 64'(st_mean);
      if (x >= mean64) begin
        mag = x - mean64;
        stp = mag / 64'(st_count);
        nm  = mean64 + stp;
        if (nm > 64'(MEAN_MAX)) nm = 64'(MEAN_MAX);
        d1 = mag;
        d2 = (x >= nm) ? x - nm : 64'd0;
      end else begin
        mag = mean64 - x;
        stp = mag / 64'(st_count);
        nm  = mean64 - stp;
        d1 = mag;
        d2 = (nm >= x) ? nm - x : 64'd0;
      end
      st_mean = nm[MEAN_W-1:0];
      // exact product, drop the fraction bits of both factors
      prod = (128'(d1) * 128'(d2)) >> (2 * FRAC);
      inc  = (prod[127:64] != '0) ? SQ_MAX : prod[63:0];
      st_sq = (st_sq > SQ_MAX - inc) ? SQ_MAX : st_sq + inc;
    end
    r.sample_count = st_count;
    r.min_rtt      = st_min;
    r.max_rtt      = st_max;
    r.mean_rtt     = st_mean;
    r.sq_dev_sum   = st_sq;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", fname, exp_v, act_v);
      err_count++;
    end
  endtask

  // one event on the input channel, with random idle cycles ahead of it
  task automatic send_event(input logic [TYPE_W-1:0] t, input logic [RTT_W-1:0] rtt);
    rrs_in_t ev;
    ev.icmp_type = t;
    ev.rtt_us    = rtt;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_stats.push_back(fold_event(ev));
    events_sent++;
  endtask

  // stop sending and let every expected result come out
  task automatic wait_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [TMO_W-1:0] val);
    logic [31:0] junk;
    junk = $urandom;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = {junk[31:TMO_W], val};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_TIMEOUT) tmo_s = val;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // mostly times inside the timeout, with boundary, tiny, full-range and extreme picks
  function automatic logic [RTT_W-1:0] random_rtt();
    logic [RTT_W-1:0] lim;
    int               pick;
    lim  = RTT_W'(tmo_s) * 32'd1000000;
    pick = $urandom_range(99);
    if (pick < 55) return $urandom_range(lim);
    if (pick < 65) return (lim < 2) ? RTT_W'($urandom_range(3)) : lim - 2 + $urandom_range(4);
    if (pick < 75) return $urandom_range(1000);
    if (pick < 90) return $urandom;
    case ($urandom_range(2))
      0: return '0;
      1: return lim;
      default: return '1;
    endcase
  endfunction

  function automatic logic [TYPE_W-1:0] random_type();
    if ($urandom_range(99) < 80) return ICMP_ECHO_REPLY;
    return TYPE_W'($urandom_range(255));
  endfunction

  // empty statistics, type and timeout filtering, first sample, mean moving both ways
  task automatic test_reset_timeout();
    send_event(ICMP_ECHO_REQ, 32'd0);
    send_event(ICMP_ECHO_REPLY, 32'd1000001);
    send_event(8'hFF, 32'hFFFF_FFFF);
    send_event(ICMP_ECHO_REPLY, 32'd1000000);
    send_event(ICMP_ECHO_REPLY, 32'd0);
    send_event(ICMP_ECHO_REPLY, 32'd500000);
    send_event(ICMP_UNREACH, 32'd10);
    send_event(ICMP_ECHO_REPLY, 32'd999999);
    wait_quiet();
  endtask

  // zero and full-scale timeout, writes to an unmapped address
  task automatic test_timeout_extremes();
    cfg_write(ADDR_TIMEOUT, TMO_MIN);
    send_event(ICMP_ECHO_REPLY, 32'd0);
    send_event(ICMP_ECHO_REPLY, 32'd1);
    send_event(8'h80, 32'd0);
    wait_quiet();
    cfg_write(ADDR_TIMEOUT, TMO_MAX);
    send_event(ICMP_ECHO_REPLY, 32'd255000000);
    send_event(ICMP_ECHO_REPLY, 32'd255000001);
    send_event(ICMP_ECHO_REPLY, 32'hFFFF_FFFF);
    send_event(ICMP_ECHO_REPLY, 32'h8000_0000);
    send_event(ICMP_ECHO_REPLY, 32'd1);
    send_event(8'h7F, 32'd1);
    wait_quiet();
    cfg_write(ADDR_UNUSED, TMO_MIN);
    send_event(ICMP_ECHO_REPLY, 32'd200000000);
    send_event(ICMP_ECHO_REPLY, 32'h5555_5555);
    wait_quiet();
    cfg_write(ADDR_TIMEOUT, TIMEOUT_RESET);
    send_event(ICMP_ECHO_REPLY, 32'd1000000);
    send_event(ICMP_ECHO_REPLY, 32'd1000001);
    wait_quiet();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [TMO_W-1:0] tmo, input int n);
    cfg_write(ADDR_TIMEOUT, tmo);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_event(random_type(), random_rtt());
    wait_quiet();
  endtask

  // alternate the widest counted times to drive the squared-deviation sum up fast
  task automatic test_wide_spread();
    cfg_write(ADDR_TIMEOUT, TMO_MAX);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < WIDE_SAMPLES; i++) begin
      send_event(ICMP_ECHO_REPLY, (i % 2 == 0) ? 32'd0 : 32'd255000000);
    end
    send_event(ICMP_ECHO_REPLY, 32'd127500000);
    send_event(8'h01, 32'd0);
    wait_quiet();
  endtask

  // result checking and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_stats.size() == 0) begin
        $error("result transfer with no event pending");
        err_count++;
      end else begin
        want = pending_stats.pop_front();
        if (want.counted) counted_seen++;
        check_field("counted", 64'(want.counted), 64'(out_data.counted));
        check_field("sample_count", 64'(want.sample_count), 64'(out_data.sample_count));
        check_field("min_rtt", 64'(want.min_rtt), 64'(out_data.min_rtt));
        check_field("max_rtt", 64'(want.max_rtt), 64'(out_data.max_rtt));
        check_field("mean_rtt", 64'(want.mean_rtt), 64'(out_data.mean_rtt));
        check_field("sq_dev_sum", want.sq_dev_sum, out_data.sq_dev_sum);
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    err_count      = 0;
    events_sent    = 0;
    results_seen   = 0;
    counted_seen   = 0;
    quiet_cycles   = 0;
    tmo_s          = TIMEOUT_RESET;
    st_count       = '0;
    st_min         = '0;
    st_max         = '0;
    st_mean        = '0;
    st_sq          = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    test_reset_timeout();
    test_timeout_extremes();
    test_random_traffic(0, 0, TMO_MAX, RANDOM_EVENTS);
    test_random_traffic(63, 0, 8'($urandom_range(2, 254)), RANDOM_EVENTS);
    test_random_traffic(0, 63, TIMEOUT_RESET, RANDOM_EVENTS);
    test_random_traffic(20, 20, 8'($urandom_range(2, 254)), RANDOM_EVENTS);
    test_wide_spread();

    $display("%0d events sent, %0d results checked, %0d of them counted samples",
             events_sent, results_seen, counted_seen);
    $display("timeouts 0, 1, 255 and random; final squared-deviation sum %0d", st_sq);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ running_rtt_statistics.f @@
src/rrs_pkg.sv
src/rrs_div.sv
src/rrs_mul.sv
src/running_rtt_statistics.sv
src/rrs_checker.sv
dv/testbench.sv
